>>> rtl/gpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gpc_pkg;

   // Default geometry of the block.
   localparam int DEFAULT_NUM_PORTS     = 3;
   localparam int DEFAULT_PINS_PER_PORT = 16;

   // Command codes.
   localparam logic [2:0] CMD_SET_MODE   = 3'd0;
   localparam logic [2:0] CMD_SET_OTYPE  = 3'd1;
   localparam logic [2:0] CMD_SET_PUPD   = 3'd2;
   localparam logic [2:0] CMD_SET_AF     = 3'd3;
   localparam logic [2:0] CMD_WRITE_PIN  = 3'd4;
   localparam logic [2:0] CMD_WRITE_PORT = 3'd5;
   localparam logic [2:0] CMD_READ_PIN   = 3'd6;
   localparam logic [2:0] CMD_TOGGLE     = 3'd7;

   // Port codes.
   localparam logic [1:0] PORT_A = 2'd0;
   localparam logic [1:0] PORT_B = 2'd1;

   // Result status codes.
   localparam logic [1:0] STATUS_DONE    = 2'd0;
   localparam logic [1:0] STATUS_DEBUG   = 2'd1;
   localparam logic [1:0] STATUS_INVALID = 2'd2;

   // Whole-port write masks that keep the debug pins untouched.
   localparam logic [15:0] PORT_A_WRITE_MASK = 16'h1FFF;
   localparam logic [15:0] PORT_B_WRITE_MASK = 16'hFFE7;

   // Debug pin numbers.
   localparam logic [3:0] PORT_A_DEBUG_FIRST = 4'd13;
   localparam logic [3:0] PORT_B_DEBUG_LOW   = 4'd3;
   localparam logic [3:0] PORT_B_DEBUG_HIGH  = 4'd4;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [1:0]  port;
      logic [3:0]  pin;
      logic [3:0]  field_value;
      logic [1:0]  speed;
      logic [15:0] port_data;
      logic [15:0] pad_levels;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        pin_value;
      logic [15:0] output_data;
   } rsp_type;

   // True for the pins that carry the debug interface.
   function automatic logic is_debug_pin(input logic [1:0] port, input logic [3:0] pin);
      logic hit;
      hit = 1'b0;
      if (port == PORT_A) begin
         hit = (pin >= PORT_A_DEBUG_FIRST);
      end else if (port == PORT_B) begin
         hit = (pin == PORT_B_DEBUG_LOW) || (pin == PORT_B_DEBUG_HIGH);
      end
      return hit;
   endfunction

endpackage

`default_nettype wire

>>> rtl/gpc_port_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module gpc_port_regs #(
   parameter int NUM_PORTS     = gpc_pkg::DEFAULT_NUM_PORTS,
   parameter int PINS_PER_PORT = gpc_pkg::DEFAULT_PINS_PER_PORT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             item_valid,
   input  wire gpc_pkg::req_type item,
   output gpc_pkg::rsp_type      result
);

   localparam int IDX_W      = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
   localparam int PORT_EXT_W = (IDX_W > 2) ? IDX_W : 2;
   localparam int PIN_IDX_W  = $clog2(PINS_PER_PORT);

   // Per-port register file, one entry per port.
   logic [PINS_PER_PORT-1:0][1:0] mode_ff   [NUM_PORTS];
   logic [PINS_PER_PORT-1:0]      otype_ff  [NUM_PORTS];
   logic [PINS_PER_PORT-1:0][1:0] ospeed_ff [NUM_PORTS];
   logic [PINS_PER_PORT-1:0][1:0] pupd_ff   [NUM_PORTS];
   logic [PINS_PER_PORT-1:0][3:0] afr_ff    [NUM_PORTS];
   logic [PINS_PER_PORT-1:0]      odr_ff    [NUM_PORTS];

   logic [PORT_EXT_W-1:0]    port_ext;
   logic [IDX_W-1:0]         port_idx;
   logic [PIN_IDX_W-1:0]     pin_idx;
   logic                     port_ok;
   logic                     pin_ok;
   logic                     debug_hit;
   logic [15:0]              port_word;
   logic [PINS_PER_PORT-1:0] odr_cur;
   logic [PINS_PER_PORT-1:0] odr_in;
   logic                     mode_we;
   logic                     otype_we;
   logic                     pupd_we;
   logic                     af_we;
   logic [1:0]               status;
   logic                     pin_value;

   // Decode the port and pin of the item.
   assign port_ext  = PORT_EXT_W'(item.port);
   assign port_idx  = port_ext[IDX_W-1:0];
   assign pin_idx   = item.pin[PIN_IDX_W-1:0];
   assign port_ok   = (32'(item.port) < NUM_PORTS);
   assign pin_ok    = (32'(item.pin) < PINS_PER_PORT);
   assign debug_hit = gpc_pkg::is_debug_pin(item.port, item.pin);
   assign odr_cur   = odr_ff[port_idx];

   // Whole-port write data with the debug pins masked off.
   always_comb begin
      port_word = item.port_data;
      if (item.port == gpc_pkg::PORT_A) begin
         port_word = item.port_data & gpc_pkg::PORT_A_WRITE_MASK;
      end else if (item.port == gpc_pkg::PORT_B) begin
         port_word = item.port_data & gpc_pkg::PORT_B_WRITE_MASK;
      end
   end

   // Command decode and the new output data word.
   always_comb begin
      status    = gpc_pkg::STATUS_DONE;
      pin_value = 1'b0;
      odr_in    = odr_cur;
      mode_we   = 1'b0;
      otype_we  = 1'b0;
      pupd_we   = 1'b0;
      af_we     = 1'b0;
      if (!port_ok) begin
         status = gpc_pkg::STATUS_INVALID;
      end else if (item.cmd == gpc_pkg::CMD_WRITE_PORT) begin
         odr_in = port_word[PINS_PER_PORT-1:0];
      end else if (debug_hit) begin
         status = gpc_pkg::STATUS_DEBUG;
      end else if (pin_ok) begin
         case (item.cmd)
            gpc_pkg::CMD_SET_MODE: begin
               mode_we = 1'b1;
            end
            gpc_pkg::CMD_SET_OTYPE: begin
               otype_we = 1'b1;
            end
            gpc_pkg::CMD_SET_PUPD: begin
               pupd_we = 1'b1;
            end
            gpc_pkg::CMD_SET_AF: begin
               af_we = 1'b1;
            end
            gpc_pkg::CMD_WRITE_PIN: begin
               odr_in[pin_idx] = item.field_value[0];
            end
            gpc_pkg::CMD_READ_PIN: begin
               pin_value = item.pad_levels[item.pin];
            end
            gpc_pkg::CMD_TOGGLE: begin
               odr_in[pin_idx] = ~odr_cur[pin_idx];
            end
            default: begin
               odr_in = odr_cur;
            end
         endcase
      end
   end

   assign result.status      = status;
   assign result.pin_value   = pin_value;
   assign result.output_data = port_ok ? 16'(odr_in) : 16'h0000;

   // Register file update; an invalid port touches nothing.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < NUM_PORTS; p++) begin
            mode_ff[p]   <= '0;
            otype_ff[p]  <= '0;
            ospeed_ff[p] <= '0;
            pupd_ff[p]   <= '0;
            afr_ff[p]    <= '0;
            odr_ff[p]    <= '0;
         end
      end else if (item_valid && port_ok) begin
         odr_ff[port_idx] <= odr_in;
         if (mode_we) begin
            mode_ff[port_idx][pin_idx] <= item.field_value[1:0];
         end
         if (otype_we) begin
            otype_ff[port_idx][pin_idx]  <= item.field_value[0];
            ospeed_ff[port_idx][pin_idx] <= item.speed;
         end
         if (pupd_we) begin
            pupd_ff[port_idx][pin_idx] <= item.field_value[1:0];
         end
         if (af_we) begin
            afr_ff[port_idx][pin_idx] <= item.field_value;
         end
      end
   end

endmodule

`default_nettype wire

>>> rtl/gpio_port_pin_controller.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                          Transfer
// --------  -----------------------------  ----------------------------------
// command   start, busy, req_payload       start high and busy low at an edge
// result    rsp_strobe, rsp_payload        rsp_strobe high for one cycle
//
// One command is taken in every cycle; busy stays low.
// A result passes first through the input register, then through the
// register file read-modify-write into the result register.
// Commands to the same port in consecutive cycles see each other's updates.
// Reset clears all port registers and drops any command in flight.
// The receiver cannot stall, so every result is shown for exactly one cycle.

module gpio_port_pin_controller #(
   parameter int NUM_PORTS     = gpc_pkg::DEFAULT_NUM_PORTS,
   parameter int PINS_PER_PORT = gpc_pkg::DEFAULT_PINS_PER_PORT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output      logic             busy,
   input  wire gpc_pkg::req_type req_payload,
   output      logic             rsp_strobe,
   output gpc_pkg::rsp_type      rsp_payload
);

   logic             item_valid_ff;
   logic             item_valid_in;
   gpc_pkg::req_type item_ff;
   gpc_pkg::rsp_type result;
   logic             rsp_strobe_ff;
   gpc_pkg::rsp_type rsp_ff;

   assign busy          = 1'b0;
   assign item_valid_in = start && !busy;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_valid_in) begin
         item_ff <= req_payload;
      end
   end

   gpc_port_regs #(
      .NUM_PORTS     (NUM_PORTS),
      .PINS_PER_PORT (PINS_PER_PORT)
   ) u_port_regs (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid_ff),
      .item       (item_ff),
      .result     (result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= item_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (item_valid_ff) begin
         rsp_ff <= result;
      end
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

   // Every accepted command reaches the result port through the input and result registers.
   a_cmd_to_rsp: assert property (@(posedge clock) disable iff (reset)
      item_valid_in |=> ##1 rsp_strobe)
      else $error("accepted command produced no result");

   // A result is only shown for a command that was in the input register.
   a_rsp_has_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(item_valid_ff))
      else $error("result without a command");

   // An invalid port reports nothing but its status.
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.status == gpc_pkg::STATUS_INVALID)
         |-> (rsp_payload.output_data == 16'h0000 && !rsp_payload.pin_value))
      else $error("invalid port result carries data");

   // Only a pin read can return a pad level.
   a_pin_value_read: assert property (@(posedge clock) disable iff (reset)
      (item_valid_ff && item_ff.cmd != gpc_pkg::CMD_READ_PIN)
         |=> !rsp_payload.pin_value)
      else $error("pin value set by a command other than a pin read");

endmodule

`default_nettype wire
